// ===== hdl/mahd_pkg.sv =====
// package for the mpeg audio header decoder: codes, widths, tables and shared types
package mahd_pkg;

	localparam logic [10:0] SYNC_ALL_ONES = 11'h7FF;

	localparam logic [1:0] VER_MPEG25   = 2'd0;
	localparam logic [1:0] VER_RESERVED = 2'd1;
	localparam logic [1:0] VER_MPEG2    = 2'd2;
	localparam logic [1:0] VER_MPEG1    = 2'd3;

	localparam logic [1:0] LAYER_RESERVED = 2'd0;
	localparam logic [1:0] LAYER_3        = 2'd1;
	localparam logic [1:0] LAYER_2        = 2'd2;
	localparam logic [1:0] LAYER_1        = 2'd3;

	localparam logic [3:0] BR_IDX_FREE   = 4'h0;
	localparam logic [3:0] BR_IDX_BAD    = 4'hF;
	localparam logic [1:0] SR_IDX_RSVD   = 2'd3;
	localparam logic [1:0] EMPH_RSVD     = 2'd2;

	localparam int BR_W    = 9;
	localparam int SR_W    = 16;
	localparam int LEN_W   = 12;
	localparam int K_W     = 8;
	localparam int N_W     = 17;
	localparam int M_W     = 20;
	localparam int Q_W     = 12;
	localparam int DIV_W   = 9;
	localparam int RECIP_W = 28;
	localparam int RECIP_SHIFT = 32;
	localparam int PROD_W  = M_W + RECIP_W;
	localparam int QD_W    = Q_W + DIV_W;

	localparam logic [K_W-1:0] K_LAYER_I = K_W'(12);
	localparam logic [K_W-1:0] K_FULL    = K_W'(144);
	localparam logic [K_W-1:0] K_HALF    = K_W'(72);

	localparam logic [DIV_W-1:0] DIV_VAL_441 = DIV_W'(441);
	localparam logic [DIV_W-1:0] DIV_VAL_48  = DIV_W'(48);
	localparam logic [DIV_W-1:0] DIV_VAL_32  = DIV_W'(32);

	localparam logic [RECIP_W-1:0] RECIP_441 = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd441);
	localparam logic [RECIP_W-1:0] RECIP_48  = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd48);
	localparam logic [RECIP_W-1:0] RECIP_32  = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd32);

	typedef enum logic [1:0] {
		DIV_441,
		DIV_48,
		DIV_32
	} div_sel_t;

	typedef struct packed {
		logic            header_ok;
		logic            length_known;
		logic            padding;
		logic            layer_one;
		logic [BR_W-1:0] bitrate;
		logic [SR_W-1:0] sample_rate;
	} side_t;

	typedef logic [BR_W-1:0] br_tab_t [16];

	localparam br_tab_t BR_V1_L1 = '{
		9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
		9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
	localparam br_tab_t BR_V1_L2 = '{
		9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
		9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
	localparam br_tab_t BR_V1_L3 = '{
		9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
		9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
	localparam br_tab_t BR_V2_L1 = '{
		9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
		9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
	localparam br_tab_t BR_V2_L23 = '{
		9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
		9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

	function automatic logic [BR_W-1:0] bitrate_lookup(
		input logic [1:0] ver,
		input logic [1:0] lay,
		input logic [3:0] idx
	);
		logic [BR_W-1:0] br;
		br = '0;
		if (ver == VER_RESERVED || lay == LAYER_RESERVED) begin
			br = '0;
		end else if (ver == VER_MPEG1) begin
			if (lay == LAYER_1) br = BR_V1_L1[idx];
			else if (lay == LAYER_2) br = BR_V1_L2[idx];
			else br = BR_V1_L3[idx];
		end else begin
			if (lay == LAYER_1) br = BR_V2_L1[idx];
			else br = BR_V2_L23[idx];
		end
		return br;
	endfunction

	function automatic logic [SR_W-1:0] rate_lookup(
		input logic [1:0] ver,
		input logic [1:0] fidx
	);
		logic [SR_W-1:0] base;
		logic [SR_W-1:0] sr;
		base = '0;
		sr = '0;
		unique case (fidx)
			2'd0: base = SR_W'(44100);
			2'd1: base = SR_W'(48000);
			2'd2: base = SR_W'(32000);
			default: base = '0;
		endcase
		unique case (ver)
			VER_MPEG1: sr = base;
			VER_MPEG2: sr = base >> 1;
			VER_MPEG25: sr = base >> 2;
			default: sr = '0;
		endcase
		return sr;
	endfunction

endpackage

// ===== hdl/mpeg_audio_header_decode.sv =====
// top level of the mpeg audio frame header decoder
// Decodes one 32-bit frame header per transaction: field checks, bitrate and sample rate
// lookup, and frame length in bytes with padding. It takes a new header every cycle while
// in_ready is high. Each header passes five registers (field decode and table lookup,
// frame-length numerator, reciprocal multiply, remainder correction, output register)
// on the way to out_valid. The frame length division is done by a constant reciprocal
// multiply picked by the sample rate family, followed by one correction step. A stalled
// output holds every stage; empty stages still fill while the output waits.
module mpeg_audio_header_decode
	import mahd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [31:0]       header_word,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              header_ok,
	output logic              length_known,
	output logic [LEN_W-1:0]  frame_bytes,
	output logic [BR_W-1:0]   bitrate_kbps,
	output logic [SR_W-1:0]   sample_rate_hz
);

	logic [10:0]      sync;
	logic [1:0]       ver;
	logic [1:0]       lay;
	logic [3:0]       bidx;
	logic [1:0]       fidx;
	logic [1:0]       emph;
	logic [BR_W-1:0]  br;
	logic [SR_W-1:0]  sr;
	logic [K_W-1:0]   kfac;
	logic [1:0]       shamt;
	div_sel_t         dsel;
	side_t            side;

	logic             v_s1;
	side_t            side_s1;
	logic [K_W-1:0]   k_s1;
	logic [1:0]       shamt_s1;
	div_sel_t         dsel_s1;

	logic             v_s2;
	side_t            side_s2;
	logic [M_W-1:0]   m_s2;
	div_sel_t         dsel_s2;

	logic             v_s5;
	logic             ok_s5;
	logic             known_s5;
	logic [LEN_W-1:0] len_s5;
	logic [BR_W-1:0]  br_s5;
	logic [SR_W-1:0]  sr_s5;

	logic             en_s1;
	logic             en_s2;
	logic             en_s5;
	logic             div_in_ready;
	logic             div_valid;
	logic [Q_W-1:0]   div_q;
	side_t            div_side;
	logic [N_W-1:0]   n_base;
	logic [N_W-1:0]   n_scaled;
	logic [M_W-1:0]   m_next;
	logic [LEN_W-1:0] q_pad;
	logic [LEN_W-1:0] len_next;

	// field decode and lookups
	assign sync = header_word[31:21];
	assign ver  = header_word[20:19];
	assign lay  = header_word[18:17];
	assign bidx = header_word[15:12];
	assign fidx = header_word[11:10];
	assign emph = header_word[1:0];

	assign br = bitrate_lookup(ver, lay, bidx);
	assign sr = rate_lookup(ver, fidx);

	always_comb begin
		side.header_ok = sync == SYNC_ALL_ONES && ver != VER_RESERVED &&
			lay != LAYER_RESERVED && bidx != BR_IDX_FREE && bidx != BR_IDX_BAD &&
			fidx != SR_IDX_RSVD && emph != EMPH_RSVD;
		side.length_known = br != '0 && sr != '0;
		side.padding      = header_word[9];
		side.layer_one    = lay == LAYER_1;
		side.bitrate      = br;
		side.sample_rate  = sr;

		if (lay == LAYER_1) kfac = K_LAYER_I;
		else if (lay == LAYER_2 || ver == VER_MPEG1) kfac = K_FULL;
		else kfac = K_HALF;

		unique case (ver)
			VER_MPEG1: shamt = 2'd0;
			VER_MPEG2: shamt = 2'd1;
			default: shamt = 2'd2;
		endcase

		unique case (fidx)
			2'd0: dsel = DIV_441;
			2'd1: dsel = DIV_48;
			default: dsel = DIV_32;
		endcase
	end

	// numerator: sample rate is base/2^shamt, so scale the numerator instead
	assign n_base   = N_W'(k_s1) * N_W'(side_s1.bitrate);
	assign n_scaled = n_base << shamt_s1;
	assign m_next   = (dsel_s1 == DIV_441) ?
		(M_W'(n_scaled) << 3) + (M_W'(n_scaled) << 1) : M_W'(n_scaled);

	assign en_s5 = !v_s5 || out_ready;
	assign en_s2 = !v_s2 || div_in_ready;
	assign en_s1 = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s5) v_s5 <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			side_s1  <= side;
			k_s1     <= kfac;
			shamt_s1 <= shamt;
			dsel_s1  <= dsel;
		end
		if (en_s2 && v_s1) begin
			side_s2 <= side_s1;
			m_s2    <= m_next;
			dsel_s2 <= dsel_s1;
		end
		if (en_s5 && div_valid) begin
			ok_s5    <= div_side.header_ok;
			known_s5 <= div_side.length_known;
			len_s5   <= div_side.length_known ? len_next : '0;
			br_s5    <= div_side.bitrate;
			sr_s5    <= div_side.sample_rate;
		end
	end

	mahd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_ready  (div_in_ready),
		.m         (m_s2),
		.dsel      (dsel_s2),
		.side_in   (side_s2),
		.out_valid (div_valid),
		.out_ready (en_s5),
		.q         (div_q),
		.side_out  (div_side)
	);

	// layer i counts in four-byte slots
	assign q_pad    = LEN_W'(div_q) + LEN_W'(div_side.padding);
	assign len_next = div_side.layer_one ? (q_pad << 2) : q_pad;

	assign out_valid      = v_s5;
	assign header_ok      = ok_s5;
	assign length_known   = known_s5;
	assign frame_bytes    = len_s5;
	assign bitrate_kbps   = br_s5;
	assign sample_rate_hz = sr_s5;

endmodule

// ===== hdl/mahd_div.sv =====
// pipelined divider: reciprocal multiply in one stage, remainder correction in the next
module mahd_div
	import mahd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [M_W-1:0]   m,
	input  div_sel_t         dsel,
	input  side_t            side_in,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [Q_W-1:0]   q,
	output side_t            side_out
);

	logic               v_s3;
	logic [M_W-1:0]     m_s3;
	logic [DIV_W-1:0]   d_s3;
	logic [Q_W-1:0]     q0_s3;
	side_t              side_s3;

	logic               v_s4;
	logic [Q_W-1:0]     q_s4;
	side_t              side_s4;

	logic               en_s3;
	logic               en_s4;
	logic [RECIP_W-1:0] recip;
	logic [DIV_W-1:0]   dval;
	logic [PROD_W-1:0]  prod;
	logic [QD_W-1:0]    qd;
	logic [QD_W-1:0]    rem;
	logic               bump;

	assign en_s4    = !v_s4 || out_ready;
	assign en_s3    = !v_s3 || en_s4;
	assign in_ready = en_s3;

	always_comb begin
		unique case (dsel)
			DIV_441: begin
				recip = RECIP_441;
				dval  = DIV_VAL_441;
			end
			DIV_48: begin
				recip = RECIP_48;
				dval  = DIV_VAL_48;
			end
			DIV_32: begin
				recip = RECIP_32;
				dval  = DIV_VAL_32;
			end
			default: begin
				recip = RECIP_32;
				dval  = DIV_VAL_32;
			end
		endcase
	end

	assign prod = PROD_W'(m) * PROD_W'(recip);

	// estimate is exact or one low
	assign qd   = QD_W'(q0_s3) * QD_W'(d_s3);
	assign rem  = QD_W'(m_s3) - qd;
	assign bump = rem >= QD_W'(d_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s3) v_s3 <= in_valid;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && in_valid) begin
			m_s3    <= m;
			d_s3    <= dval;
			q0_s3   <= prod[RECIP_SHIFT +: Q_W];
			side_s3 <= side_in;
		end
		if (en_s4 && v_s3) begin
			q_s4    <= q0_s3 + Q_W'(bump);
			side_s4 <= side_s3;
		end
	end

	assign out_valid = v_s4;
	assign q         = q_s4;
	assign side_out  = side_s4;

endmodule

// ===== hdl/mahd_checker.sv =====
// port-level checker for the mpeg audio header decoder, bound to the top level
module mahd_checker
	import mahd_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic [31:0]       header_word,
	input logic              out_valid,
	input logic              out_ready,
	input logic              header_ok,
	input logic              length_known,
	input logic [LEN_W-1:0]  frame_bytes,
	input logic [BR_W-1:0]   bitrate_kbps,
	input logic [SR_W-1:0]   sample_rate_hz
);

	// stalled result transaction stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frame_bytes) &&
		$stable(bitrate_kbps) && $stable(sample_rate_hz) && $stable(header_ok))
		else $error("result changed while stalled");

	// a passing header always has a computable length
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && header_ok |-> length_known)
		else $error("header passes but length unknown");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !length_known |-> frame_bytes == '0)
		else $error("frame length without known rates");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && length_known |->
		bitrate_kbps != '0 && sample_rate_hz != '0 && frame_bytes != '0)
		else $error("known length with zero rate or length");

endmodule

bind mpeg_audio_header_decode mahd_checker u_mahd_checker (.*);

// ===== tb/header_decode_check.sv =====
// result checker for the mpeg audio header decoder: predicts each header and compares in order
module header_decode_check
	import mahd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  logic [31:0]      header_word,
	input  logic             out_valid,
	input  logic             out_ready,
	input  logic             header_ok,
	input  logic             length_known,
	input  logic [LEN_W-1:0] frame_bytes,
	input  logic [BR_W-1:0]  bitrate_kbps,
	input  logic [SR_W-1:0]  sample_rate_hz,
	output int               fail_count,
	output int               pending_count
);

	typedef struct packed {
		logic             ok;
		logic             known;
		logic [LEN_W-1:0] bytes;
		logic [BR_W-1:0]  kbps;
		logic [SR_W-1:0]  hz;
	} decoded_t;

	localparam logic [BR_W-1:0] KBPS_M1_L1 [16] = '{
		9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
		9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
	localparam logic [BR_W-1:0] KBPS_M1_L2 [16] = '{
		9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
		9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
	localparam logic [BR_W-1:0] KBPS_M1_L3 [16] = '{
		9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
		9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
	localparam logic [BR_W-1:0] KBPS_M2_L1 [16] = '{
		9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
		9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
	localparam logic [BR_W-1:0] KBPS_M2_L23 [16] = '{
		9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
		9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

	decoded_t decoded_q [$];
	decoded_t want;

	function automatic decoded_t decode_header(input logic [31:0] w);
		logic [10:0] sync;
		logic [1:0] ver;
		logic [1:0] lay;
		logic [3:0] bidx;
		logic [1:0] fidx;
		logic pad;
		logic [1:0] emph;
		int unsigned kbps;
		int unsigned hz;
		int unsigned len;
		decoded_t d;
		sync = w[31:21];
		ver = w[20:19];
		lay = w[18:17];
		bidx = w[15:12];
		fidx = w[11:10];
		pad = w[9];
		emph = w[1:0];
		kbps = 0;
		if (ver != VER_RESERVED && lay != LAYER_RESERVED) begin
			if (ver == VER_MPEG1) begin
				if (lay == LAYER_1) kbps = KBPS_M1_L1[bidx];
				else if (lay == LAYER_2) kbps = KBPS_M1_L2[bidx];
				else kbps = KBPS_M1_L3[bidx];
			end else if (lay == LAYER_1) begin
				kbps = KBPS_M2_L1[bidx];
			end else begin
				kbps = KBPS_M2_L23[bidx];
			end
		end
		case ({ver, fidx})
			{VER_MPEG1, 2'd0}:  hz = 44100;
			{VER_MPEG1, 2'd1}:  hz = 48000;
			{VER_MPEG1, 2'd2}:  hz = 32000;
			{VER_MPEG2, 2'd0}:  hz = 22050;
			{VER_MPEG2, 2'd1}:  hz = 24000;
			{VER_MPEG2, 2'd2}:  hz = 16000;
			{VER_MPEG25, 2'd0}: hz = 11025;
			{VER_MPEG25, 2'd1}: hz = 12000;
			{VER_MPEG25, 2'd2}: hz = 8000;
			default:            hz = 0;
		endcase
		len = 0;
		d.known = (kbps != 0) && (hz != 0);
		if (d.known) begin
			if (lay == LAYER_1) len = (12 * kbps * 1000 / hz + pad) * 4;
			else if (lay == LAYER_2 || ver == VER_MPEG1) len = 144 * kbps * 1000 / hz + pad;
			else len = 72 * kbps * 1000 / hz + pad;
		end
		d.ok = sync == SYNC_ALL_ONES && ver != VER_RESERVED && lay != LAYER_RESERVED &&
			bidx != BR_IDX_FREE && bidx != BR_IDX_BAD && fidx != SR_IDX_RSVD &&
			emph != EMPH_RSVD;
		d.bytes = LEN_W'(len);
		d.kbps = BR_W'(kbps);
		d.hz = SR_W'(hz);
		return d;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			decoded_q.delete();
			fail_count = 0;
			pending_count = 0;
		end else begin
			if (in_valid && in_ready) decoded_q.push_back(decode_header(header_word));
			if (out_valid && out_ready) begin
				if (decoded_q.size() == 0) begin
					$display("%0t: result transaction with no header waiting", $time);
					fail_count++;
				end else begin
					want = decoded_q.pop_front();
					if (header_ok !== want.ok) begin
						$display("%0t: header_ok expected %0b got %0b", $time, want.ok, header_ok);
						fail_count++;
					end
					if (length_known !== want.known) begin
						$display("%0t: length_known expected %0b got %0b", $time, want.known,
							length_known);
						fail_count++;
					end
					if (frame_bytes !== want.bytes) begin
						$display("%0t: frame_bytes expected %0d got %0d", $time, want.bytes,
							frame_bytes);
						fail_count++;
					end
					if (bitrate_kbps !== want.kbps) begin
						$display("%0t: bitrate_kbps expected %0d got %0d", $time, want.kbps,
							bitrate_kbps);
						fail_count++;
					end
					if (sample_rate_hz !== want.hz) begin
						$display("%0t: sample_rate_hz expected %0d got %0d", $time, want.hz,
							sample_rate_hz);
						fail_count++;
					end
				end
			end
			pending_count = decoded_q.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
// testbench top for the mpeg audio header decoder: header stimulus, result stalls and verdict
module testbench;
	import mahd_pkg::*;

	localparam int RANDOM_HEADERS = 1730;
	localparam int HOLD_AT        = 500;
	localparam int PAUSE_AT       = 1100;
	localparam int LONG_HOLD      = 300;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [31:0]      header_word = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic             header_ok;
	logic             length_known;
	logic [LEN_W-1:0] frame_bytes;
	logic [BR_W-1:0]  bitrate_kbps;
	logic [SR_W-1:0]  sample_rate_hz;
	int               fail_count;
	int               pending_count;
	int               hold_requests = 0;

	mpeg_audio_header_decode DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.header_word(header_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.header_ok(header_ok),
		.length_known(length_known),
		.frame_bytes(frame_bytes),
		.bitrate_kbps(bitrate_kbps),
		.sample_rate_hz(sample_rate_hz)
	);

	header_decode_check decode_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.header_word(header_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.header_ok(header_ok),
		.length_known(length_known),
		.frame_bytes(frame_bytes),
		.bitrate_kbps(bitrate_kbps),
		.sample_rate_hz(sample_rate_hz),
		.fail_count(fail_count),
		.pending_count(pending_count)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic logic [31:0] header_of(
		input logic [10:0] sync,
		input logic [1:0]  ver,
		input logic [1:0]  lay,
		input logic        prot,
		input logic [3:0]  bidx,
		input logic [1:0]  fidx,
		input logic        pad,
		input logic [6:0]  misc,
		input logic [1:0]  emph
	);
		return {sync, ver, lay, prot, bidx, fidx, pad, misc, emph};
	endfunction

	task automatic offer(input logic [31:0] w);
		@(negedge clk);
		in_valid <= 1'b1;
		header_word <= w;
		do @(posedge clk); while (in_ready !== 1'b1);
	endtask

	task automatic rest(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	task automatic drain;
		@(negedge clk);
		while (pending_count != 0) @(negedge clk);
	endtask

	// result side: stall patterns that change per segment, plus long holds on request
	initial begin : result_sink
		int seg_left;
		int mode;
		int phase;
		int period;
		int low_len;
		int holds_served;
		seg_left = 0;
		mode = 0;
		phase = 0;
		period = 2;
		low_len = 1;
		holds_served = 0;
		forever begin
			@(negedge clk);
			if (hold_requests != holds_served) begin
				holds_served = hold_requests;
				out_ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else begin
				if (seg_left == 0) begin
					seg_left = $urandom_range(20, 150);
					mode = $urandom_range(0, 3);
					period = $urandom_range(2, 9);
					low_len = $urandom_range(1, period - 1);
					phase = 0;
				end
				seg_left--;
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ($urandom_range(0, 7) != 0);
					default: out_ready <= (phase >= low_len);
				endcase
				phase = (phase + 1) % period;
			end
		end
	end

	initial begin : header_source
		int burst_left;
		logic [10:0] sync;
		logic [1:0] ver;
		logic [1:0] lay;
		logic [3:0] bidx;
		logic [1:0] fidx;
		logic [31:0] w;
		burst_left = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed headers
		offer(32'h0000_0000);
		offer(32'hFFFF_FFFF);
		offer(header_of(SYNC_ALL_ONES, VER_MPEG1, LAYER_1, 1'b0, 4'd1, 2'd0, 1'b0, 7'h00, 2'd0));
		offer(header_of(SYNC_ALL_ONES, VER_MPEG1, LAYER_1, 1'b0, 4'd14, 2'd2, 1'b1, 7'h00, 2'd0));
		offer(header_of(SYNC_ALL_ONES, VER_MPEG1, LAYER_2, 1'b0, 4'd14, 2'd2, 1'b1, 7'h00, 2'd0));
		offer(header_of(SYNC_ALL_ONES, VER_MPEG1, LAYER_3, 1'b0, 4'd1, 2'd0, 1'b1, 7'h00, 2'd0));
		offer(header_of(SYNC_ALL_ONES, VER_MPEG1, LAYER_3, 1'b0, 4'd14, 2'd1, 1'b0, 7'h00, 2'd1));
		offer(header_of(SYNC_ALL_ONES, VER_MPEG2, LAYER_1, 1'b0, 4'd14, 2'd2, 1'b1, 7'h00, 2'd0));
		offer(header_of(SYNC_ALL_ONES, VER_MPEG2, LAYER_2, 1'b0, 4'd7, 2'd0, 1'b0, 7'h00, 2'd0));
		offer(header_of(SYNC_ALL_ONES, VER_MPEG2, LAYER_3, 1'b0, 4'd1, 2'd1, 1'b1, 7'h00, 2'd3));
		offer(header_of(SYNC_ALL_ONES, VER_MPEG25, LAYER_1, 1'b0, 4'd14, 2'd2, 1'b1, 7'h00, 2'd0));
		// longest possible frame
		offer(header_of(SYNC_ALL_ONES, VER_MPEG25, LAYER_2, 1'b0, 4'd14, 2'd2, 1'b1, 7'h00, 2'd0));
		offer(header_of(SYNC_ALL_ONES, VER_MPEG25, LAYER_3, 1'b0, 4'd14, 2'd2, 1'b1, 7'h00, 2'd0));
		offer(header_of(SYNC_ALL_ONES, VER_MPEG1, LAYER_2, 1'b0, BR_IDX_FREE, 2'd0, 1'b0, 7'h00,
			2'd0));
		offer(header_of(SYNC_ALL_ONES, VER_MPEG1, LAYER_2, 1'b0, BR_IDX_BAD, 2'd0, 1'b0, 7'h00,
			2'd0));
		offer(header_of(SYNC_ALL_ONES, VER_MPEG1, LAYER_3, 1'b0, 4'd9, SR_IDX_RSVD, 1'b0, 7'h00,
			2'd0));
		offer(header_of(SYNC_ALL_ONES, VER_RESERVED, LAYER_3, 1'b0, 4'd9, 2'd0, 1'b0, 7'h00,
			2'd0));
		offer(header_of(SYNC_ALL_ONES, VER_MPEG1, LAYER_RESERVED, 1'b0, 4'd9, 2'd0, 1'b0, 7'h00,
			2'd0));
		offer(header_of(11'h7FE, VER_MPEG1, LAYER_3, 1'b0, 4'd9, 2'd0, 1'b1, 7'h00, 2'd0));
		offer(header_of(11'h000, VER_MPEG2, LAYER_1, 1'b0, 4'd5, 2'd1, 1'b0, 7'h00, 2'd0));
		offer(header_of(SYNC_ALL_ONES, VER_MPEG1, LAYER_3, 1'b0, 4'd9, 2'd0, 1'b0, 7'h00,
			EMPH_RSVD));
		offer(header_of(SYNC_ALL_ONES, VER_MPEG2, LAYER_3, 1'b1, 4'd8, 2'd2, 1'b1, 7'h7F, 2'd1));
		offer(header_of(SYNC_ALL_ONES, VER_MPEG25, LAYER_3, 1'b1, 4'd1, 2'd0, 1'b0, 7'h55, 2'd0));
		rest(1);
		drain();

		// random headers, mostly well formed
		for (int i = 0; i < RANDOM_HEADERS; i++) begin
			if (i == HOLD_AT) hold_requests++;
			if (i == PAUSE_AT) begin
				rest(1);
				drain();
				rest($urandom_range(1, 20));
			end
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				if ($urandom_range(0, 3) != 0) rest($urandom_range(1, 12));
			end
			burst_left--;
			if ($urandom_range(0, 3) == 0) begin
				w = $urandom();
			end else begin
				sync = ($urandom_range(0, 19) == 0) ? 11'($urandom()) : SYNC_ALL_ONES;
				if ($urandom_range(0, 15) == 0) begin
					ver = VER_RESERVED;
				end else begin
					case ($urandom_range(0, 2))
						0: ver = VER_MPEG25;
						1: ver = VER_MPEG2;
						default: ver = VER_MPEG1;
					endcase
				end
				lay = ($urandom_range(0, 15) == 0) ? LAYER_RESERVED : 2'($urandom_range(1, 3));
				bidx = ($urandom_range(0, 7) == 0) ? 4'($urandom()) : 4'($urandom_range(1, 14));
				fidx = ($urandom_range(0, 7) == 0) ? SR_IDX_RSVD : 2'($urandom_range(0, 2));
				w = header_of(sync, ver, lay, 1'($urandom()), bidx, fidx, 1'($urandom()),
					7'($urandom()), 2'($urandom()));
			end
			offer(w);
		end
		rest(1);
		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
